FILE: hdl/vdc_pkg.sv
// ----------------------------------------------------------------------------
// vdc_pkg
// Types, codes and helpers shared by the valve dispense controller files.
// ----------------------------------------------------------------------------
package vdc_pkg;

  localparam int unsigned VolW  = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [VolW-1:0] SETTLE_MS_RESET = VolW'(500);

  typedef enum logic [2:0] {
    CMD_UPDATE = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_ABORT  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_RUNNING  = 3'd1,
    ST_PAUSED   = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_STALLED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [VolW-1:0]  fill_ml;
    logic [VolW-1:0]  sensor_ml;
    logic             sensor_stalled;
    logic [TimeW-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic            valve_on;
    logic            flow_armed;
    logic            sensor_clear;
    logic [VolW-1:0] delivered_ml;
    logic [VolW-1:0] target_out;
  } rsp_t;

  // Saturating volume add, clamps at all ones.
  function automatic logic [VolW-1:0] sat_add(input logic [VolW-1:0] a,
                                              input logic [VolW-1:0] b);
    logic [VolW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[VolW] ? {VolW{1'b1}} : sum[VolW-1:0];
  endfunction

endpackage

FILE: hdl/vdc_cmd_if.sv
// ----------------------------------------------------------------------------
// vdc_cmd_if
// Command channel: valid/ready handshake with one command item as payload.
// ----------------------------------------------------------------------------
interface vdc_cmd_if import vdc_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/vdc_rsp_if.sv
// ----------------------------------------------------------------------------
// vdc_rsp_if
// Result channel: valid/ready handshake with one status report as payload.
// ----------------------------------------------------------------------------
interface vdc_rsp_if import vdc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/vdc_cfg_if.sv
// ----------------------------------------------------------------------------
// vdc_cfg_if
// Configuration write channel carrying the settle time in milliseconds.
// ----------------------------------------------------------------------------
interface vdc_cfg_if import vdc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VolW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/valve_dispense_controller.sv
// ----------------------------------------------------------------------------
// valve_dispense_controller
// Valve dispense controller: command decode, volume banking and settle timer.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle while the result side is not
// stalled and returns exactly one status report per command, in order. A
// command transfers into an input register; its effect on the controller
// state and its report are computed from that register and land in a result
// register, from which the report transfers when the result side is ready.
// Throughput is one command per cycle without a stall; the state update
// path holds two saturating volume adds and one 32-bit elapsed-time compare.
// A stalled result side holds both registers and backpressures the command
// side. The settle time register is always ready and should be written only
// while no command is in flight.
// ----------------------------------------------------------------------------
module valve_dispense_controller import vdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  vdc_cmd_if.sink   cmd_i,
  vdc_cfg_if.sink   cfg_i,
  vdc_rsp_if.source rsp_o
);

  logic [VolW-1:0]  settle_ms_q;

  logic             in_valid_q;
  cmd_t             in_q;
  logic             out_valid_q;
  rsp_t             out_q;
  rsp_t             out_d;
  logic             advance;

  status_e          mode_q, mode_d;
  logic [VolW-1:0]  target_q, target_d;
  logic [VolW-1:0]  banked_q, banked_d;
  logic             valve_q, valve_d;
  logic             settling_q, settling_d;
  logic             armed_q, armed_d;
  logic [TimeW-1:0] settle_begin_q, settle_begin_d;

  logic             pulse;
  logic             flowing;
  logic [VolW-1:0]  bank_add;
  logic [TimeW-1:0] elapsed;
  logic [VolW-1:0]  cur_sensor;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign flowing  = valve_q || settling_q;
  assign bank_add = sat_add(banked_q, flowing ? in_q.sensor_ml : '0);
  assign elapsed  = in_q.now_ms - settle_begin_q;

  always_comb begin
    mode_d         = mode_q;
    target_d       = target_q;
    banked_d       = banked_q;
    valve_d        = valve_q;
    settling_d     = settling_q;
    armed_d        = armed_q;
    settle_begin_d = settle_begin_q;
    pulse          = 1'b0;

    case (cmd_e'(in_q.command))
      CMD_UPDATE: begin
        if (mode_q == ST_RUNNING) begin
          if (in_q.sensor_stalled) begin
            banked_d   = bank_add;
            valve_d    = 1'b0;
            armed_d    = 1'b0;
            settling_d = 1'b0;
            mode_d     = ST_STALLED;
          end else if (bank_add >= target_q) begin
            // close valve, keep counting through the settle window
            valve_d        = 1'b0;
            settling_d     = 1'b1;
            settle_begin_d = in_q.now_ms;
            mode_d         = ST_COMPLETE;
          end
        end else if (mode_q == ST_COMPLETE && settling_q) begin
          if (elapsed >= {{(TimeW-VolW){1'b0}}, settle_ms_q}) begin
            banked_d   = bank_add;
            settling_d = 1'b0;
            armed_d    = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (in_q.fill_ml != '0 && mode_q != ST_RUNNING) begin
          target_d   = in_q.fill_ml;
          banked_d   = '0;
          settling_d = 1'b0;
          mode_d     = ST_RUNNING;
          pulse      = 1'b1;
          valve_d    = 1'b1;
          armed_d    = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (mode_q == ST_RUNNING) begin
          banked_d   = bank_add;
          valve_d    = 1'b0;
          armed_d    = 1'b0;
          settling_d = 1'b0;
          mode_d     = ST_PAUSED;
        end
      end
      CMD_RESUME: begin
        if (mode_q == ST_PAUSED) begin
          pulse   = 1'b1;
          valve_d = 1'b1;
          armed_d = 1'b1;
          mode_d  = ST_RUNNING;
        end
      end
      CMD_ABORT: begin
        if (mode_q != ST_IDLE) begin
          banked_d   = bank_add;
          valve_d    = 1'b0;
          armed_d    = 1'b0;
          settling_d = 1'b0;
          // stalled and complete keep their status
          if (mode_q == ST_RUNNING || mode_q == ST_PAUSED) begin
            mode_d = ST_COMPLETE;
          end
        end
      end
      CMD_CLEAR: begin
        valve_d    = 1'b0;
        armed_d    = 1'b0;
        settling_d = 1'b0;
        mode_d     = ST_IDLE;
        target_d   = '0;
        banked_d   = '0;
      end
      default: begin
      end
    endcase
  end

  // Sensor is being zeroed on a pulse: report banked volume only.
  assign cur_sensor = pulse ? '0 : in_q.sensor_ml;

  always_comb begin
    out_d.status       = mode_d;
    out_d.valve_on     = valve_d;
    out_d.flow_armed   = armed_d;
    out_d.sensor_clear = pulse;
    out_d.delivered_ml = sat_add(banked_d, (valve_d || settling_d) ? cur_sensor : '0);
    out_d.target_out   = target_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ms_q <= SETTLE_MS_RESET;
    end else if (cfg_i.valid) begin
      settle_ms_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ST_IDLE;
      target_q       <= '0;
      banked_q       <= '0;
      valve_q        <= 1'b0;
      settling_q     <= 1'b0;
      armed_q        <= 1'b0;
      settle_begin_q <= '0;
    end else if (advance) begin
      mode_q         <= mode_d;
      target_q       <= target_d;
      banked_q       <= banked_d;
      valve_q        <= valve_d;
      settling_q     <= settling_d;
      armed_q        <= armed_d;
      settle_begin_q <= settle_begin_d;
    end
  end

endmodule
